// File: sv/scsa_pkg.sv
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared types, constants and class tables of the size-class slab allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

	localparam int NUM_CLASSES    = 17;
	localparam int DEF_POOL_PAGES = 64;
	localparam int ADDR_W         = 48;
	localparam int PAGE_HI_W      = 36;
	localparam int OFF_W          = 12;
	localparam int BYTES_W        = 16;
	localparam int SIZE_W         = 12;
	localparam int SLOT_W         = 8;
	localparam int TAKEN_W        = 9;
	localparam int CLASS_W        = 5;
	localparam int WSEL_W         = 2;
	localparam int WCNT_W         = 3;
	localparam int REGION_W       = 13;
	localparam int INFO_W         = CLASS_W + TAKEN_W;
	localparam int MAP_W          = 64;
	localparam int BIT_W          = 6;
	localparam int STATUS_W       = 3;
	localparam int MAX_SMALL      = 2048;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK, ST_NULL, ST_TOO_LARGE, ST_NO_PAGES,
		ST_FOREIGN, ST_PAST_REGION, ST_MISALIGNED, ST_DOUBLE_FREE
	} status_t;

	typedef enum logic [3:0] {
		OP_IDLE, OP_LOAD, OP_DECODE, OP_SCAN, OP_WORD, OP_GRANT,
		OP_CLR, OP_FCHK, OP_DIV, OP_FBIT, OP_OUT
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SCAN, S_WORD, S_GRANT, S_CLR,
		S_FCHK, S_DIV, S_FBIT, S_OUT
	} fsm_state_t;

	typedef struct packed {
		logic is_free;
		logic decode_err;
		logic scan_hit;
		logic scan_last;
		logic free_avail;
		logic word_found;
		logic word_more;
		logic clr_last;
		logic fchk_err;
		logic div_done;
		logic div_err;
		logic out_space;
	} dp_status_t;

	function automatic logic [SIZE_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
		logic [SIZE_W-1:0] r;
		case (c)
			5'd0:    r = 12'd16;
			5'd1:    r = 12'd24;
			5'd2:    r = 12'd32;
			5'd3:    r = 12'd48;
			5'd4:    r = 12'd64;
			5'd5:    r = 12'd80;
			5'd6:    r = 12'd96;
			5'd7:    r = 12'd128;
			5'd8:    r = 12'd160;
			5'd9:    r = 12'd192;
			5'd10:   r = 12'd256;
			5'd11:   r = 12'd384;
			5'd12:   r = 12'd512;
			5'd13:   r = 12'd768;
			5'd14:   r = 12'd1024;
			5'd15:   r = 12'd1536;
			5'd16:   r = 12'd2048;
			default: r = 12'd2048;
		endcase
		return r;
	endfunction

	function automatic logic [TAKEN_W-1:0] class_slots(input logic [CLASS_W-1:0] c);
		logic [TAKEN_W-1:0] r;
		case (c)
			5'd0:    r = 9'd256;
			5'd1:    r = 9'd170;
			5'd2:    r = 9'd128;
			5'd3:    r = 9'd85;
			5'd4:    r = 9'd64;
			5'd5:    r = 9'd51;
			5'd6:    r = 9'd42;
			5'd7:    r = 9'd32;
			5'd8:    r = 9'd25;
			5'd9:    r = 9'd21;
			5'd10:   r = 9'd16;
			5'd11:   r = 9'd10;
			5'd12:   r = 9'd8;
			5'd13:   r = 9'd5;
			5'd14:   r = 9'd4;
			5'd15:   r = 9'd2;
			5'd16:   r = 9'd2;
			default: r = 9'd2;
		endcase
		return r;
	endfunction

	// slot region size in bytes: slots * size
	function automatic logic [REGION_W-1:0] class_region(input logic [CLASS_W-1:0] c);
		logic [REGION_W-1:0] r;
		case (c)
			5'd0:    r = 13'd4096;
			5'd1:    r = 13'd4080;
			5'd2:    r = 13'd4096;
			5'd3:    r = 13'd4080;
			5'd4:    r = 13'd4096;
			5'd5:    r = 13'd4080;
			5'd6:    r = 13'd4032;
			5'd7:    r = 13'd4096;
			5'd8:    r = 13'd4000;
			5'd9:    r = 13'd4032;
			5'd10:   r = 13'd4096;
			5'd11:   r = 13'd3840;
			5'd12:   r = 13'd4096;
			5'd13:   r = 13'd3840;
			5'd14:   r = 13'd4096;
			5'd15:   r = 13'd3072;
			5'd16:   r = 13'd4096;
			default: r = 13'd4096;
		endcase
		return r;
	endfunction

	function automatic logic [WCNT_W-1:0] class_words(input logic [CLASS_W-1:0] c);
		logic [TAKEN_W:0] s;
		s = {1'b0, class_slots(c)} + 10'd63;
		return WCNT_W'(s >> 6);
	endfunction

	// bits past the slot count in the last bitmap word are held set
	function automatic logic [MAP_W-1:0] tail_mask(input logic [CLASS_W-1:0] c);
		logic [TAKEN_W-1:0] n;
		logic [BIT_W-1:0]   s;
		n = class_slots(c);
		s = n[BIT_W-1:0];
		if (s == '0) begin
			return '0;
		end
		return ~((MAP_W'(1) << s) - MAP_W'(1));
	endfunction

	function automatic logic [CLASS_W-1:0] class_of(input logic [BYTES_W-1:0] n);
		logic [CLASS_W-1:0] r;
		r = CLASS_W'(NUM_CLASSES - 1);
		for (int c = NUM_CLASSES - 2; c >= 0; c--) begin
			if (n <= BYTES_W'(class_bytes(CLASS_W'(c)))) begin
				r = CLASS_W'(c);
			end
		end
		return r;
	endfunction

endpackage

// File: sv/scsa_ram.sv
// ----------------------------------------------------------------------------
// scsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scsa_ram #(
	parameter int WIDTH  = scsa_pkg::INFO_W,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/scsa_div.sv
// ----------------------------------------------------------------------------
// scsa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scsa_div #(
	parameter int W = scsa_pkg::SIZE_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem,
	output logic         done
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quot_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic [W:0]    trial;

	assign shifted = {rem_q, quot_q[W-1]};
	assign trial   = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
		end else if (busy_q) begin
			rem_q  <= trial[W] ? shifted[W-1:0] : trial[W-1:0];
			quot_q <= {quot_q[W-2:0], ~trial[W]};
		end
	end

	assign quot = quot_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule

// File: sv/scsa_dp.sv
// ----------------------------------------------------------------------------
// scsa_dp
// Allocator datapath: page tables, bitmaps, checks, result and output register.
// ----------------------------------------------------------------------------
module scsa_dp #(
	parameter int POOL_PAGES = scsa_pkg::DEF_POOL_PAGES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  scsa_pkg::dp_op_t               op,
	input  logic                           cmd_in,
	input  logic [scsa_pkg::BYTES_W-1:0]   bytes_in,
	input  logic [scsa_pkg::ADDR_W-1:0]    faddr_in,
	input  logic                           cfg_valid,
	input  logic [scsa_pkg::ADDR_W-1:0]    cfg_data,
	input  logic                           m_tready,
	output logic                           m_tvalid,
	output logic [scsa_pkg::ADDR_W-1:0]    out_addr,
	output logic [scsa_pkg::SIZE_W-1:0]    out_freed,
	output logic [scsa_pkg::STATUS_W-1:0]  out_status,
	output scsa_pkg::dp_status_t           status
);

	localparam int PW  = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
	localparam int PCW = $clog2(POOL_PAGES + 1);
	localparam int BW  = PW + scsa_pkg::WSEL_W;
	localparam int AW  = scsa_pkg::ADDR_W;
	localparam int HW  = scsa_pkg::PAGE_HI_W;
	localparam int OW  = scsa_pkg::OFF_W;
	localparam int CLW = scsa_pkg::CLASS_W;
	localparam int TW  = scsa_pkg::TAKEN_W;
	localparam int SW  = scsa_pkg::SIZE_W;
	localparam int MW  = scsa_pkg::MAP_W;
	localparam int WSW = scsa_pkg::WSEL_W;
	localparam int WCW = scsa_pkg::WCNT_W;

	logic [AW-1:0]                 base_q;
	logic                          cmd_q;
	logic [scsa_pkg::BYTES_W-1:0]  bytes_q;
	logic [AW-1:0]                 faddr_q;
	logic [CLW-1:0]                cls_q;
	logic [PCW-1:0]                p_q;
	logic [PW-1:0]                 free_p_q;
	logic                          free_found_q;
	logic                          skip_q;
	logic [WCW-1:0]                w_q;
	logic [TW-1:0]                 taken_q;
	logic [POOL_PAGES-1:0]         in_use_q;
	logic [PCW-1:0]                ppc_q [scsa_pkg::NUM_CLASSES];
	logic [AW-1:0]                 res_addr_q;
	logic [SW-1:0]                 res_freed_q;
	scsa_pkg::status_t             res_status_q;
	logic                          out_valid_q;
	logic [AW-1:0]                 out_addr_q;
	logic [SW-1:0]                 out_freed_q;
	scsa_pkg::status_t             out_status_q;

	logic                          info_we;
	logic [PW-1:0]                 info_waddr;
	logic [scsa_pkg::INFO_W-1:0]   info_wdata;
	logic [PW-1:0]                 info_raddr;
	logic [scsa_pkg::INFO_W-1:0]   info_rdata;
	logic                          bm_we;
	logic [BW-1:0]                 bm_waddr;
	logic [MW-1:0]                 bm_wdata;
	logic [BW-1:0]                 bm_raddr;
	logic [MW-1:0]                 bm_rdata;

	logic [PW-1:0]                 p_idx;
	logic [PCW-1:0]                p_next;
	logic [HW-1:0]                 page_diff;
	logic [PW-1:0]                 diff_idx;
	scsa_pkg::status_t             decode_code;
	scsa_pkg::status_t             fchk_code;
	logic [CLW-1:0]                ri_cls;
	logic [TW-1:0]                 ri_taken;
	logic                          cur_used;
	logic                          scan_hit;
	logic                          scan_last;
	logic [scsa_pkg::BIT_W-1:0]    bpos;
	logic                          word_found;
	logic [WCW-1:0]                w_next;
	logic [scsa_pkg::SLOT_W-1:0]   slot_num;
	logic [SW+scsa_pkg::SLOT_W-1:0] slot_off;
	logic [HW-1:0]                 page_hi;
	logic [SW-1:0]                 size_cur;
	logic [TW-1:0]                 taken_dec;
	logic                          release_page;
	logic                          div_start;
	logic [SW-1:0]                 div_quot;
	logic [SW-1:0]                 div_rem;
	logic                          div_done;
	logic                          fbit_set;
	logic [MW-1:0]                 fbit_mask;

	assign p_idx     = p_q[PW-1:0];
	assign p_next    = p_q + PCW'(1);
	assign page_diff = faddr_q[AW-1:OW] - base_q[AW-1:OW];
	assign diff_idx  = page_diff[PW-1:0];
	assign ri_cls    = info_rdata[scsa_pkg::INFO_W-1:TW];
	assign ri_taken  = info_rdata[TW-1:0];
	assign cur_used  = in_use_q[p_idx];
	assign scan_hit  = cur_used && (ri_cls == cls_q) && !skip_q &&
		(ri_taken != scsa_pkg::class_slots(cls_q));
	assign scan_last = (p_q == PCW'(POOL_PAGES - 1));
	assign size_cur  = scsa_pkg::class_bytes(cls_q);
	assign page_hi   = base_q[AW-1:OW] + HW'(p_q);
	assign w_next    = w_q + WCW'(1);

	always_comb begin
		bpos = '0;
		for (int i = MW - 1; i >= 0; i--) begin
			if (!bm_rdata[i]) begin
				bpos = scsa_pkg::BIT_W'(i);
			end
		end
	end

	assign word_found = ~&bm_rdata;
	assign slot_num   = {w_q[WSW-1:0], bpos};
	assign slot_off   = (SW + scsa_pkg::SLOT_W)'(slot_num) * (SW + scsa_pkg::SLOT_W)'(size_cur);

	always_comb begin
		if (!cmd_q) begin
			if (bytes_q == '0) begin
				decode_code = scsa_pkg::ST_NULL;
			end else if (bytes_q > scsa_pkg::BYTES_W'(scsa_pkg::MAX_SMALL)) begin
				decode_code = scsa_pkg::ST_TOO_LARGE;
			end else begin
				decode_code = scsa_pkg::ST_OK;
			end
		end else begin
			if (faddr_q == '0) begin
				decode_code = scsa_pkg::ST_NULL;
			end else if (page_diff >= HW'(POOL_PAGES)) begin
				decode_code = scsa_pkg::ST_FOREIGN;
			end else if (!in_use_q[diff_idx]) begin
				decode_code = scsa_pkg::ST_FOREIGN;
			end else begin
				decode_code = scsa_pkg::ST_OK;
			end
		end
	end

	always_comb begin
		if (ri_cls >= CLW'(scsa_pkg::NUM_CLASSES)) begin
			fchk_code = scsa_pkg::ST_FOREIGN;
		end else if ({1'b0, faddr_q[OW-1:0]} >= scsa_pkg::class_region(ri_cls)) begin
			fchk_code = scsa_pkg::ST_PAST_REGION;
		end else begin
			fchk_code = scsa_pkg::ST_OK;
		end
	end

	assign div_start    = (op == scsa_pkg::OP_FCHK) && (fchk_code == scsa_pkg::ST_OK);
	assign fbit_mask    = MW'(1) << div_quot[scsa_pkg::BIT_W-1:0];
	assign fbit_set     = |(bm_rdata & fbit_mask);
	assign taken_dec    = (taken_q == '0) ? '0 : taken_q - TW'(1);
	assign release_page = (taken_dec == '0) && (ppc_q[cls_q] > PCW'(1));

	scsa_div #(.W(SW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (faddr_q[OW-1:0]),
		.divisor  (size_cur),
		.quot     (div_quot),
		.rem      (div_rem),
		.done     (div_done)
	);

	// memory ports
	always_comb begin
		info_we    = 1'b0;
		info_waddr = p_idx;
		info_wdata = {cls_q, taken_dec};
		bm_we      = 1'b0;
		bm_waddr   = {p_idx, w_q[WSW-1:0]};
		bm_wdata   = bm_rdata & ~fbit_mask;
		info_raddr = p_idx;
		bm_raddr   = {p_idx, w_q[WSW-1:0]};
		case (op)
			scsa_pkg::OP_DECODE: begin
				info_raddr = cmd_q ? diff_idx : '0;
			end
			scsa_pkg::OP_SCAN: begin
				info_raddr = p_next[PW-1:0];
				bm_raddr   = {p_idx, WSW'(0)};
			end
			scsa_pkg::OP_WORD: begin
				bm_raddr   = {p_idx, w_next[WSW-1:0]};
				info_we    = word_found;
				info_wdata = {cls_q, taken_q + TW'(1)};
				bm_we      = word_found;
				bm_wdata   = bm_rdata | (MW'(1) << bpos);
			end
			scsa_pkg::OP_GRANT: begin
				info_we    = 1'b1;
				info_waddr = free_p_q;
				info_wdata = {cls_q, TW'(0)};
			end
			scsa_pkg::OP_CLR: begin
				bm_we    = 1'b1;
				bm_wdata = (w_q == scsa_pkg::class_words(cls_q) - WCW'(1)) ?
					scsa_pkg::tail_mask(cls_q) : '0;
				bm_raddr = {p_idx, WSW'(0)};
			end
			scsa_pkg::OP_DIV: begin
				bm_raddr = {p_idx, div_quot[scsa_pkg::SLOT_W-1:scsa_pkg::BIT_W]};
			end
			scsa_pkg::OP_FBIT: begin
				info_we  = fbit_set;
				bm_we    = fbit_set;
				bm_waddr = {p_idx, div_quot[scsa_pkg::SLOT_W-1:scsa_pkg::BIT_W]};
			end
			default: begin
			end
		endcase
	end

	scsa_ram #(.WIDTH(scsa_pkg::INFO_W), .ADDR_W(PW)) u_info_ram (
		.clk   (clk),
		.we    (info_we),
		.waddr (info_waddr),
		.wdata (info_wdata),
		.raddr (info_raddr),
		.rdata (info_rdata)
	);

	scsa_ram #(.WIDTH(MW), .ADDR_W(BW)) u_map_ram (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.raddr (bm_raddr),
		.rdata (bm_rdata)
	);

	// control state: config, page ownership, pages per class, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			in_use_q    <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < scsa_pkg::NUM_CLASSES; c++) begin
				ppc_q[c] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				base_q <= cfg_data;
			end
			if (op == scsa_pkg::OP_GRANT) begin
				in_use_q[free_p_q] <= 1'b1;
				ppc_q[cls_q]       <= ppc_q[cls_q] + PCW'(1);
			end
			if (op == scsa_pkg::OP_FBIT && fbit_set && release_page) begin
				in_use_q[p_idx] <= 1'b0;
				ppc_q[cls_q]    <= ppc_q[cls_q] - PCW'(1);
			end
			if (op == scsa_pkg::OP_OUT && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			scsa_pkg::OP_LOAD: begin
				cmd_q        <= cmd_in;
				bytes_q      <= bytes_in;
				faddr_q      <= faddr_in;
				p_q          <= '0;
				free_found_q <= 1'b0;
				skip_q       <= 1'b0;
			end
			scsa_pkg::OP_DECODE: begin
				cls_q <= scsa_pkg::class_of(bytes_q);
				if (cmd_q) begin
					p_q <= PCW'(diff_idx);
				end
				res_addr_q   <= '0;
				res_freed_q  <= '0;
				res_status_q <= decode_code;
			end
			scsa_pkg::OP_SCAN: begin
				skip_q <= 1'b0;
				if (scan_hit) begin
					w_q     <= '0;
					taken_q <= ri_taken;
				end else begin
					if (!free_found_q && !cur_used) begin
						free_p_q     <= p_idx;
						free_found_q <= 1'b1;
					end
					p_q          <= p_next;
					res_status_q <= scsa_pkg::ST_NO_PAGES;
				end
			end
			scsa_pkg::OP_WORD: begin
				if (word_found) begin
					res_addr_q   <= {page_hi, slot_off[OW-1:0]};
					res_status_q <= scsa_pkg::ST_OK;
				end else begin
					w_q <= w_next;
					if (w_next >= scsa_pkg::class_words(cls_q)) begin
						skip_q <= 1'b1;
					end
				end
			end
			scsa_pkg::OP_GRANT: begin
				p_q     <= PCW'(free_p_q);
				taken_q <= '0;
				w_q     <= '0;
			end
			scsa_pkg::OP_CLR: begin
				w_q <= (w_q == WCW'(scsa_pkg::WSEL_W'(-1))) ? '0 : w_next;
			end
			scsa_pkg::OP_FCHK: begin
				cls_q        <= ri_cls;
				taken_q      <= ri_taken;
				res_status_q <= fchk_code;
			end
			scsa_pkg::OP_DIV: begin
				res_status_q <= scsa_pkg::ST_MISALIGNED;
			end
			scsa_pkg::OP_FBIT: begin
				if (fbit_set) begin
					res_freed_q  <= size_cur;
					res_status_q <= scsa_pkg::ST_OK;
				end else begin
					res_status_q <= scsa_pkg::ST_DOUBLE_FREE;
				end
			end
			scsa_pkg::OP_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_addr_q   <= res_addr_q;
					out_freed_q  <= res_freed_q;
					out_status_q <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign status.is_free    = cmd_q;
	assign status.decode_err = (decode_code != scsa_pkg::ST_OK);
	assign status.scan_hit   = scan_hit;
	assign status.scan_last  = scan_last;
	assign status.free_avail = free_found_q || !cur_used;
	assign status.word_found = word_found;
	assign status.word_more  = (w_next < scsa_pkg::class_words(cls_q));
	assign status.clr_last   = (w_q == WCW'(scsa_pkg::WSEL_W'(-1)));
	assign status.fchk_err   = (fchk_code != scsa_pkg::ST_OK);
	assign status.div_done   = div_done;
	assign status.div_err    = (div_rem != '0);
	assign status.out_space  = !out_valid_q || m_tready;

	assign m_tvalid   = out_valid_q;
	assign out_addr   = out_addr_q;
	assign out_freed  = out_freed_q;
	assign out_status = out_status_q;

endmodule

// File: sv/scsa_ctrl.sv
// ----------------------------------------------------------------------------
// scsa_ctrl
// Request sequencer: steps the datapath through allocate and free.
// ----------------------------------------------------------------------------
module scsa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  scsa_pkg::dp_status_t status,
	output logic                 s_tready,
	output scsa_pkg::dp_op_t     op
);

	scsa_pkg::fsm_state_t state_q;
	scsa_pkg::fsm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scsa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op       = scsa_pkg::OP_IDLE;
		s_tready = 1'b0;
		case (state_q)
			scsa_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					op      = scsa_pkg::OP_LOAD;
					state_d = scsa_pkg::S_DECODE;
				end
			end
			scsa_pkg::S_DECODE: begin
				op = scsa_pkg::OP_DECODE;
				if (status.decode_err) begin
					state_d = scsa_pkg::S_OUT;
				end else if (status.is_free) begin
					state_d = scsa_pkg::S_FCHK;
				end else begin
					state_d = scsa_pkg::S_SCAN;
				end
			end
			scsa_pkg::S_SCAN: begin
				op = scsa_pkg::OP_SCAN;
				if (status.scan_hit) begin
					state_d = scsa_pkg::S_WORD;
				end else if (status.scan_last) begin
					state_d = status.free_avail ? scsa_pkg::S_GRANT : scsa_pkg::S_OUT;
				end
			end
			scsa_pkg::S_WORD: begin
				op = scsa_pkg::OP_WORD;
				if (status.word_found) begin
					state_d = scsa_pkg::S_OUT;
				end else if (!status.word_more) begin
					// page turned out full: resume the scan past it
					state_d = scsa_pkg::S_SCAN;
				end
			end
			scsa_pkg::S_GRANT: begin
				op      = scsa_pkg::OP_GRANT;
				state_d = scsa_pkg::S_CLR;
			end
			scsa_pkg::S_CLR: begin
				op = scsa_pkg::OP_CLR;
				if (status.clr_last) begin
					state_d = scsa_pkg::S_WORD;
				end
			end
			scsa_pkg::S_FCHK: begin
				op      = scsa_pkg::OP_FCHK;
				state_d = status.fchk_err ? scsa_pkg::S_OUT : scsa_pkg::S_DIV;
			end
			scsa_pkg::S_DIV: begin
				op = scsa_pkg::OP_DIV;
				if (status.div_done) begin
					state_d = status.div_err ? scsa_pkg::S_OUT : scsa_pkg::S_FBIT;
				end
			end
			scsa_pkg::S_FBIT: begin
				op      = scsa_pkg::OP_FBIT;
				state_d = scsa_pkg::S_OUT;
			end
			scsa_pkg::S_OUT: begin
				op = scsa_pkg::OP_OUT;
				if (status.out_space) begin
					state_d = scsa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = scsa_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: sv/size_class_slab_allocator.sv
// ----------------------------------------------------------------------------
// size_class_slab_allocator
// Slab allocator over a fixed page pool with 17 slot classes.
// ----------------------------------------------------------------------------
// One request at a time: an allocate or a free goes in, exactly one result
// comes out. An allocate walks the pool pages one per cycle (page table RAM
// read pipelined with the check), pausing to read the bitmap words of each
// candidate page of its class one per cycle; when a fresh page has to be
// granted, its 4 bitmap words are first cleared one per cycle. A free runs
// the serial divider that turns the page offset into a slot number. Requests
// rejected at decode skip straight to the output step. A finished result
// sits in the output register, and the next request is taken once it has
// moved there.
// ----------------------------------------------------------------------------
module size_class_slab_allocator #(
	parameter int POOL_PAGES = scsa_pkg::DEF_POOL_PAGES
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: pool_base
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [47:0] cfg_data,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [15:0] request_bytes, [63:16] free_address
	input  logic        s_tuser,   // command: 0 allocate, 1 free
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [47:0] slot_address, [59:48] freed_bytes, [63:60] zero
	output logic [2:0]  m_tuser    // status
);

	scsa_pkg::dp_op_t     op;
	scsa_pkg::dp_status_t dp_status;
	logic [47:0]          out_addr;
	logic [11:0]          out_freed;

	assign cfg_ready = 1'b1;

	scsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.status   (dp_status),
		.s_tready (s_tready),
		.op       (op)
	);

	scsa_dp #(.POOL_PAGES(POOL_PAGES)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.cmd_in     (s_tuser),
		.bytes_in   (s_tdata[15:0]),
		.faddr_in   (s_tdata[63:16]),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.out_addr   (out_addr),
		.out_freed  (out_freed),
		.out_status (m_tuser),
		.status     (dp_status)
	);

	assign m_tdata = {4'b0000, out_freed, out_addr};

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while another is in flight");

	a_fail_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != scsa_pkg::ST_OK) |-> (m_tdata[59:0] == '0))
		else $error("failed request carries an address or size");

	a_free_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[59:48] != '0) |-> (m_tdata[47:0] == '0))
		else $error("free result carries a slot address");
`endif

endmodule

// File: tb/tb_size_class_slab_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_size_class_slab_allocator
// Drives allocate and free requests into the slab allocator over several
// pool base settings, predicts every result with its own copy of the page
// pool and bitmaps, and compares each result transaction field by field.
// ----------------------------------------------------------------------------

class slab_scoreboard;
	localparam int PAGES = 64;
	bit [47:0] base_reg;
	bit        in_use [PAGES];
	bit [4:0]  page_class [PAGES];
	bit [63:0] bitmap [PAGES*4];
	int        taken [PAGES];
	int        class_pages [scsa_pkg::NUM_CLASSES];
	bit [47:0] exp_addr [$];
	bit [11:0] exp_freed [$];
	scsa_pkg::status_t exp_status [$];
	bit [47:0] live_slots [$];
	int        errors;

	function void clear();
		foreach (in_use[p]) begin
			in_use[p] = 0; page_class[p] = 0; taken[p] = 0;
		end
		foreach (bitmap[w]) bitmap[w] = 0;
		foreach (class_pages[c]) class_pages[c] = 0;
		base_reg = 0;
	endfunction

	function int slot_bytes(int c);
		int tbl [scsa_pkg::NUM_CLASSES] = '{16, 24, 32, 48, 64, 80, 96, 128, 160, 192,
			256, 384, 512, 768, 1024, 1536, 2048};
		return tbl[c];
	endfunction

	function int slot_count(int c);
		int tbl [scsa_pkg::NUM_CLASSES] = '{256, 170, 128, 85, 64, 51, 42, 32, 25, 21,
			16, 10, 8, 5, 4, 2, 2};
		return tbl[c];
	endfunction

	function bit [47:0] page_addr(int p);
		return {base_reg[47:12], 12'h000} + 48'(p) * 48'd4096;
	endfunction

	function bit claim_slot(int p, int c, output bit [47:0] a);
		int nw;
		nw = (slot_count(c) + 63) / 64;
		for (int w = 0; w < nw; w++)
			for (int b = 0; b < 64; b++)
				if (!bitmap[p*4+w][b]) begin
					bitmap[p*4+w][b] = 1;
					taken[p]++;
					a = page_addr(p) + 48'((w*64 + b) * slot_bytes(c));
					return 1;
				end
		return 0;
	endfunction

	function scsa_pkg::status_t allocate(int n, output bit [47:0] a);
		int c, p, rem;
		a = 0;
		if (n == 0) return scsa_pkg::ST_NULL;
		if (n > 2048) return scsa_pkg::ST_TOO_LARGE;
		c = scsa_pkg::NUM_CLASSES - 1;
		for (int k = scsa_pkg::NUM_CLASSES - 2; k >= 0; k--)
			if (n <= slot_bytes(k)) c = k;
		for (p = 0; p < PAGES; p++)
			if (in_use[p] && page_class[p] == c && taken[p] != slot_count(c)
				&& claim_slot(p, c, a))
				return scsa_pkg::ST_OK;
		for (p = 0; p < PAGES; p++)
			if (!in_use[p]) break;
		if (p >= PAGES) return scsa_pkg::ST_NO_PAGES;
		in_use[p] = 1; page_class[p] = 5'(c); taken[p] = 0;
		for (int w = 0; w < 4; w++) bitmap[p*4+w] = 0;
		rem = slot_count(c) % 64;
		if (rem != 0)
			bitmap[p*4 + (slot_count(c)+63)/64 - 1] = ~((64'd1 << rem) - 64'd1);
		class_pages[c]++;
		void'(claim_slot(p, c, a));
		return scsa_pkg::ST_OK;
	endfunction

	function scsa_pkg::status_t release_slot(bit [47:0] a, output bit [11:0] fr);
		bit [47:0] diff;
		int p, c, sz, off, s;
		fr = 0;
		if (a == 0) return scsa_pkg::ST_NULL;
		diff = {a[47:12], 12'h000} - {base_reg[47:12], 12'h000};
		if (diff[47:12] >= PAGES) return scsa_pkg::ST_FOREIGN;
		p = int'(diff[47:12]);
		if (!in_use[p]) return scsa_pkg::ST_FOREIGN;
		c = page_class[p];
		sz = slot_bytes(c);
		off = a[11:0];
		if (off >= sz * slot_count(c)) return scsa_pkg::ST_PAST_REGION;
		if (off % sz != 0) return scsa_pkg::ST_MISALIGNED;
		s = off / sz;
		if (!bitmap[p*4 + s/64][s%64]) return scsa_pkg::ST_DOUBLE_FREE;
		bitmap[p*4 + s/64][s%64] = 0;
		if (taken[p] > 0) taken[p]--;
		if (taken[p] == 0 && class_pages[c] > 1) begin
			in_use[p] = 0;
			class_pages[c]--;
		end
		fr = 12'(sz);
		return scsa_pkg::ST_OK;
	endfunction

	function void note_request(bit is_free, bit [15:0] n, bit [47:0] a);
		bit [47:0] got;
		bit [11:0] fr;
		scsa_pkg::status_t st;
		got = 0; fr = 0;
		if (is_free) st = release_slot(a, fr);
		else st = allocate(n, got);
		if (!is_free && st == scsa_pkg::ST_OK && got != 0) live_slots.push_back(got);
		exp_addr.push_back(got);
		exp_freed.push_back(fr);
		exp_status.push_back(st);
	endfunction

	function void check_result(bit [63:0] d, bit [2:0] st);
		bit [47:0] ea;
		bit [11:0] ef;
		scsa_pkg::status_t es;
		if (exp_status.size() == 0) begin
			$error("result transaction with no request pending");
			errors++;
			return;
		end
		ea = exp_addr.pop_front();
		ef = exp_freed.pop_front();
		es = exp_status.pop_front();
		if (d[47:0] !== ea) begin
			$error("slot_address exp %h got %h", ea, d[47:0]); errors++;
		end
		if (d[59:48] !== ef) begin
			$error("freed_bytes exp %0d got %0d", ef, d[59:48]); errors++;
		end
		if (st !== es) begin
			$error("status exp %0d got %0d", es, st); errors++;
		end
	endfunction
endclass

module tb_size_class_slab_allocator;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [47:0] cfg_data = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [63:0] s_tdata = 0;   // [15:0] request_bytes, [63:16] free_address
	logic        s_tuser = 0;   // command
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [63:0] m_tdata;       // [47:0] slot_address, [59:48] freed_bytes
	logic [2:0]  m_tuser;       // status

	slab_scoreboard sb = new();
	bit  calm;       // no idling in the last part
	int  quiet;      // cycles without any transaction

	size_class_slab_allocator DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// receiver: random stall bursts
	initial begin
		int hold;
		forever begin
			@(posedge clk);
			if (!calm && hold == 0 && $urandom_range(0, 5) == 0)
				hold = $urandom_range(1, 12);
			if (hold > 0) begin
				hold--;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// valid stays up after a transaction; the next request replaces the data
	task automatic send(bit is_free, bit [15:0] n, bit [47:0] a);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser  <= is_free;
		s_tdata  <= {a, n};
		do @(posedge clk); while (!s_tready);
		sb.note_request(is_free, n, a);
	endtask

	task automatic write_base(bit [47:0] v);
		s_tvalid <= 0;
		while (sb.exp_status.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		cfg_valid <= 1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.base_reg = v;
		sb.live_slots.delete();
	endtask

	// random allocates of assorted sizes, frees of live slots, and some broken addresses
	task automatic random_item();
		int r, k;
		bit [47:0] a;
		bit [15:0] n;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			if ($urandom_range(0, 3) == 0) n = 16'($urandom);
			else if ($urandom_range(0, 2) == 0) n = 16'($urandom_range(0, 2049));
			else n = 16'($urandom_range(1, 256));
			send(0, n, 0);
		end else if (r < 85 && sb.live_slots.size() > 0) begin
			k = $urandom_range(0, sb.live_slots.size() - 1);
			a = sb.live_slots[k];
			if ($urandom_range(0, 9) != 0) sb.live_slots.delete(k);
			send(1, 0, a);
		end else begin
			a = {sb.base_reg[47:12], 12'h000} + 48'($urandom_range(0, 70) * 4096)
				+ 48'($urandom_range(0, 4095));
			if ($urandom_range(0, 4) == 0) a = {16'($urandom), 32'($urandom)};
			send(1, 0, a);
		end
	endtask

	initial begin
		bit [47:0] bases [4];
		bit [47:0] first;
		bases = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h0000_1234_5FFF, 48'hFFFF_FFFF_E000};
		sb.clear();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, null, too-large, foreign, misaligned and double-free requests
		send(0, 0, 0);
		send(0, 16'hFFFF, 0);
		send(0, 2049, 0);
		send(0, 2048, 0);
		send(0, 1, 0);
		first = sb.live_slots[sb.live_slots.size()-1];
		send(0, 17, 0);
		send(1, 0, 0);
		send(1, 0, 48'hFFFF_FFFF_FFFF);
		send(1, 0, first + 8);
		send(1, 0, 48'h1000 + 48'd3072);
		send(1, 0, first);
		send(1, 0, first);
		send(1, 0, 48'h1000);
		send(1, 0, 48'h1000 + 48'd2048);

		for (int ph = 0; ph < 4; ph++) begin
			write_base(bases[ph] ^ (ph == 2 ? 48'($urandom) : 48'h0));
			if (ph == 1)
				for (int i = 0; i < 70; i++) send(0, 16'($urandom_range(1537, 2048)), 0);
			if (ph == 3) calm = 1;
			for (int i = 0; i < 400; i++) random_item();
		end

		s_tvalid <= 0;
		while (sb.exp_status.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
